### sv/vau_pkg.sv
`default_nettype none

package vau_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_LEN   = 3'd5,
    OP_NORM  = 3'd6
  } op_t;

endpackage

`default_nettype wire

### sv/vector3_arith_unit.sv
// three-component vector alu on signed fixed-point words (default Q16.16)
// input channel: in_valid/in_ready with op, a_x..a_z, b_x..b_z and scale_factor;
// an item is taken at a clock edge where in_valid and in_ready are both high
// output channel: out_valid/out_ready with res_x..res_z, res_scalar, saturated
// every item gives exactly one result, in order
// pipeline from acceptance to out_valid: two multiply/add stages, one load stage,
// WORD_BITS square-root stages (two radicand bits each), WORD_BITS+FRAC_BITS
// divider stages (one quotient bit each, three dividers side by side), one
// output register
// throughput: one item per cycle unless the receiver stalls, every op takes the same path
// when the receiver stalls the whole pipeline holds and in_ready drops;
// in_ready is high whenever the output register is empty or being taken
// reset (rst, synchronous) clears all valid bits; payload is not reset
`default_nettype none

module vector3_arith_unit #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  op,
  input  logic signed [WORD_BITS-1:0] a_x,
  input  logic signed [WORD_BITS-1:0] a_y,
  input  logic signed [WORD_BITS-1:0] a_z,
  input  logic signed [WORD_BITS-1:0] b_x,
  input  logic signed [WORD_BITS-1:0] b_y,
  input  logic signed [WORD_BITS-1:0] b_z,
  input  logic signed [WORD_BITS-1:0] scale_factor,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] res_x,
  output logic signed [WORD_BITS-1:0] res_y,
  output logic signed [WORD_BITS-1:0] res_z,
  output logic signed [WORD_BITS-1:0] res_scalar,
  output logic                        saturated
);

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW   = W + F;
  localparam int PW   = 2 * W;
  localparam int SQ_N = W;
  localparam int DV_N = DW;
  localparam int P    = 1 + SQ_N + DV_N;

  typedef struct packed {
    vau_pkg::op_t         op;
    logic [2:0][W-1:0]    er;
    logic [W-1:0]         ers;
    logic                 esat;
    logic [PW-1:0]        rad;
    logic [W:0]           srem;
    logic [W-1:0]         root;
    logic [2:0]           neg;
    logic [2:0][DW-1:0]   dvd;
    logic [2:0][W-1:0]    drem;
    logic [2:0][DW-1:0]   q;
  } pipe_t;

  function automatic logic [W:0] clip_w(input logic signed [PW+1:0] v);
    logic signed [PW+1:0] mx;
    logic signed [PW+1:0] mn;
    mx = '0;
    mx[W-2:0] = '1;
    mn = '1;
    mn[W-2:0] = '0;
    if (v > mx) begin
      return {1'b1, mx[W-1:0]};
    end else if (v < mn) begin
      return {1'b1, mn[W-1:0]};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: products and add/sub
  logic signed [W-1:0] in_a [3];
  logic signed [W-1:0] in_b [3];
  logic signed [W-1:0] ma [6];
  logic signed [W-1:0] mb [6];
  vau_pkg::op_t        in_op;

  assign in_a[0] = a_x;
  assign in_a[1] = a_y;
  assign in_a[2] = a_z;
  assign in_b[0] = b_x;
  assign in_b[1] = b_y;
  assign in_b[2] = b_z;
  assign in_op   = vau_pkg::op_t'(op);

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (in_op)
      vau_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = in_a[i];
          mb[2*i] = scale_factor;
        end
      end
      vau_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = in_a[i];
          mb[2*i] = in_b[i];
        end
      end
      vau_pkg::OP_CROSS: begin
        ma[0] = a_y; mb[0] = b_z;
        ma[1] = a_z; mb[1] = b_y;
        ma[2] = a_z; mb[2] = b_x;
        ma[3] = a_x; mb[3] = b_z;
        ma[4] = a_x; mb[4] = b_y;
        ma[5] = a_y; mb[5] = b_x;
      end
      vau_pkg::OP_LEN, vau_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[2*i] = in_a[i];
          mb[2*i] = in_a[i];
        end
      end
      default: ;
    endcase
  end

  logic                 s1_v;
  vau_pkg::op_t         s1_op;
  logic signed [PW-1:0] s1_p [6];
  logic signed [W:0]    s1_as [3];
  logic [2:0]           s1_neg;
  logic [W-1:0]         s1_mag [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= in_op;
      for (int i = 0; i < 6; i++) begin
        s1_p[i] <= ma[i] * mb[i];
      end
      for (int i = 0; i < 3; i++) begin
        if (in_op == vau_pkg::OP_SUB) begin
          s1_as[i] <= (W+1)'(in_a[i]) - (W+1)'(in_b[i]);
        end else begin
          s1_as[i] <= (W+1)'(in_a[i]) + (W+1)'(in_b[i]);
        end
        s1_neg[i] <= in_a[i][W-1];
        s1_mag[i] <= in_a[i][W-1] ? W'(~in_a[i] + W'(1)) : in_a[i];
      end
    end
  end

  // stage 2: cross differences and three-term sum
  logic                 s2_v;
  vau_pkg::op_t         s2_op;
  logic signed [PW:0]   s2_e [3];
  logic signed [PW+1:0] s2_sum;
  logic signed [W:0]    s2_as [3];
  logic [2:0]           s2_neg;
  logic [W-1:0]         s2_mag [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op  <= s1_op;
      s2_neg <= s1_neg;
      s2_sum <= (PW+2)'(s1_p[0]) + (PW+2)'(s1_p[2]) + (PW+2)'(s1_p[4]);
      for (int i = 0; i < 3; i++) begin
        s2_e[i]   <= (PW+1)'(s1_p[2*i]) - (PW+1)'(s1_p[2*i+1]);
        s2_as[i]  <= s1_as[i];
        s2_mag[i] <= s1_mag[i];
      end
    end
  end

  // load stage, square-root stages, divider stages
  pipe_t          pp [P];
  pipe_t          pn [P];
  logic [P-1:0]   pv;

  always_comb begin
    logic [W:0] c;
    c = '0;
    pn[0] = '0;
    pn[0].op  = s2_op;
    pn[0].neg = s2_neg;
    pn[0].rad = s2_sum[PW-1:0];
    for (int i = 0; i < 3; i++) begin
      pn[0].dvd[i] = {s2_mag[i], {F{1'b0}}};
    end
    case (s2_op)
      vau_pkg::OP_ADD, vau_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          c = clip_w((PW+2)'(s2_as[i]));
          pn[0].er[i] = c[W-1:0];
          pn[0].esat  = pn[0].esat | c[W];
        end
      end
      vau_pkg::OP_SCALE, vau_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          c = clip_w((PW+2)'(s2_e[i]) >>> F);
          pn[0].er[i] = c[W-1:0];
          pn[0].esat  = pn[0].esat | c[W];
        end
      end
      vau_pkg::OP_DOT: begin
        c = clip_w(s2_sum >>> F);
        pn[0].ers  = c[W-1:0];
        pn[0].esat = c[W];
      end
      default: ;
    endcase
  end

  for (genvar k = 1; k < P; k++) begin : g_stage
    always_comb begin
      logic [W+2:0] r4;
      logic [W+2:0] trial;
      logic [W:0]   r2;
      r4    = '0;
      trial = '0;
      r2    = '0;
      pn[k] = pp[k-1];
      if (k <= SQ_N) begin
        r4    = {pp[k-1].srem, pp[k-1].rad[PW-1:PW-2]};
        trial = {1'b0, pp[k-1].root, 2'b01};
        pn[k].rad = {pp[k-1].rad[PW-3:0], 2'b00};
        if (r4 >= trial) begin
          pn[k].srem = (W+1)'(r4 - trial);
          pn[k].root = {pp[k-1].root[W-2:0], 1'b1};
        end else begin
          pn[k].srem = r4[W:0];
          pn[k].root = {pp[k-1].root[W-2:0], 1'b0};
        end
      end else begin
        for (int j = 0; j < 3; j++) begin
          r2 = {pp[k-1].drem[j], pp[k-1].dvd[j][DW-1]};
          pn[k].dvd[j] = {pp[k-1].dvd[j][DW-2:0], 1'b0};
          if (r2 >= {1'b0, pp[k-1].root}) begin
            pn[k].drem[j] = W'(r2 - {1'b0, pp[k-1].root});
            pn[k].q[j]    = {pp[k-1].q[j][DW-2:0], 1'b1};
          end else begin
            pn[k].drem[j] = r2[W-1:0];
            pn[k].q[j]    = {pp[k-1].q[j][DW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pp[k] <= pn[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp[0] <= pn[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[P-2:0], s2_v};
    end
  end

  // output stage: length clip and quotient sign/clip
  pipe_t          lst;
  logic [DW-1:0]  half;
  logic [2:0][W-1:0] o_v;
  logic [W-1:0]   o_s;
  logic           o_sat;

  assign lst = pp[P-1];

  always_comb begin
    half = '0;
    half[W-1] = 1'b1;
    o_v   = lst.er;
    o_s   = lst.ers;
    o_sat = lst.esat;
    case (lst.op)
      vau_pkg::OP_LEN: begin
        if (lst.root[W-1]) begin
          o_s   = ~half[W-1:0];
          o_sat = 1'b1;
        end else begin
          o_s = lst.root;
        end
      end
      vau_pkg::OP_NORM: begin
        if (lst.root != '0) begin
          for (int j = 0; j < 3; j++) begin
            if (lst.neg[j]) begin
              if (lst.q[j] > half) begin
                o_v[j] = half[W-1:0];
                o_sat  = 1'b1;
              end else begin
                o_v[j] = W'(~lst.q[j][W-1:0] + W'(1));
              end
            end else begin
              if (lst.q[j] >= half) begin
                o_v[j] = ~half[W-1:0];
                o_sat  = 1'b1;
              end else begin
                o_v[j] = lst.q[j][W-1:0];
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pv[P-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x      <= o_v[0];
      res_y      <= o_v[1];
      res_z      <= o_v[2];
      res_scalar <= o_s;
      saturated  <= o_sat;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pv) && $stable(s1_v) && $stable(s2_v))
    else $error("pipeline moved during a stall");

  a_s1_to_s2: assert property (@(posedge clk) disable iff (rst)
    en && s1_v |=> s2_v)
    else $error("item lost between first and second stage");

  a_vec_or_scalar: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_x != '0 || res_y != '0 || res_z != '0) |-> res_scalar == '0)
    else $error("vector and scalar result both non-zero");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    en && pv[P-1] |=> out_valid)
    else $error("item lost at output register");

endmodule

`default_nettype wire

### test/testbench.sv
`default_nettype none

module testbench;

  localparam logic signed [127:0] WORD_MAX = 128'sh7fff_ffff;
  localparam logic signed [127:0] WORD_MIN = -WORD_MAX - 128'sd1;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] s;
    logic        sat;
  } vec_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  op;
  logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scale_factor;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] res_x, res_y, res_z, res_scalar;
  logic        saturated;

  vec_result_t pending_results[$];
  int errors;
  int idle_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  vector3_arith_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .scale_factor(scale_factor),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_x(res_x), .res_y(res_y), .res_z(res_z), .res_scalar(res_scalar),
    .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] clip_word(input logic signed [127:0] v, inout logic sat);
    if (v > WORD_MAX) begin
      sat = 1'b1;
      return WORD_MAX[31:0];
    end
    if (v < WORD_MIN) begin
      sat = 1'b1;
      return WORD_MIN[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] wide(input logic signed [31:0] w);
    return 128'(w);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] sq);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (({64'd0, c} * {64'd0, c}) <= sq) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] unit_comp(input logic signed [31:0] w, input logic [63:0] len,
                                            inout logic sat);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (w < 0) ? 128'(-wide(w)) : 128'(wide(w));
    q = (mag << 16) / {64'd0, len};
    if (w < 0) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return WORD_MIN[31:0];
      end
      return 32'(-q);
    end
    if (q > 128'h7fff_ffff) begin
      sat = 1'b1;
      return WORD_MAX[31:0];
    end
    return q[31:0];
  endfunction

  function automatic vec_result_t vector_alu_result(
      input logic [2:0] code, input logic signed [31:0] ax, ay, az, bx, by, bz, k);
    vec_result_t r;
    logic sat;
    logic signed [127:0] sq;
    logic [63:0] len;
    r = '0;
    sat = 1'b0;
    case (vau_pkg::op_t'(code))
      vau_pkg::OP_ADD: begin
        r.x = clip_word(wide(ax) + wide(bx), sat);
        r.y = clip_word(wide(ay) + wide(by), sat);
        r.z = clip_word(wide(az) + wide(bz), sat);
      end
      vau_pkg::OP_SUB: begin
        r.x = clip_word(wide(ax) - wide(bx), sat);
        r.y = clip_word(wide(ay) - wide(by), sat);
        r.z = clip_word(wide(az) - wide(bz), sat);
      end
      vau_pkg::OP_SCALE: begin
        r.x = clip_word((wide(ax) * wide(k)) >>> 16, sat);
        r.y = clip_word((wide(ay) * wide(k)) >>> 16, sat);
        r.z = clip_word((wide(az) * wide(k)) >>> 16, sat);
      end
      vau_pkg::OP_DOT: begin
        r.s = clip_word((wide(ax) * wide(bx) + wide(ay) * wide(by) + wide(az) * wide(bz))
                        >>> 16, sat);
      end
      vau_pkg::OP_CROSS: begin
        r.x = clip_word((wide(ay) * wide(bz) - wide(az) * wide(by)) >>> 16, sat);
        r.y = clip_word((wide(az) * wide(bx) - wide(ax) * wide(bz)) >>> 16, sat);
        r.z = clip_word((wide(ax) * wide(by) - wide(ay) * wide(bx)) >>> 16, sat);
      end
      vau_pkg::OP_LEN, vau_pkg::OP_NORM: begin
        sq = wide(ax) * wide(ax) + wide(ay) * wide(ay) + wide(az) * wide(az);
        len = floor_sqrt(128'(sq));
        if (vau_pkg::op_t'(code) == vau_pkg::OP_LEN) begin
          r.s = clip_word(128'(len), sat);
        end else if (len != 0) begin
          r.x = unit_comp(ax, len, sat);
          r.y = unit_comp(ay, len, sat);
          r.z = unit_comp(az, len, sat);
        end
      end
      default: ;
    endcase
    r.sat = sat;
    return r;
  endfunction

  task automatic send_item(input logic [2:0] code, input logic signed [31:0] ax, ay, az,
                           input logic signed [31:0] bx, by, bz, k);
    logic accepted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz;
    scale_factor <= k;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      if (in_ready) begin
        pending_results.push_back(vector_alu_result(code, ax, ay, az, bx, by, bz, k));
        accepted = 1'b1;
      end
      @(posedge clk);
    end
  endtask

  // mix of full-range, small, and extreme words
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
      7: return 32'h7fff_ffff - $urandom_range(3);
      8: return 32'h8000_0000 + $urandom_range(3);
      default: return ($urandom_range(1)) ? 32'd0 : 32'(-($urandom_range(3) << 16));
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] mx, mn, one;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    one = 32'sh0001_0000;
    for (int c = vau_pkg::OP_ADD; c <= vau_pkg::OP_NORM; c++) begin
      send_item(3'(c), mx, mn, one, mx, mn, -one, mx);
      send_item(3'(c), mn, mn, mn, mn, mn, mn, mn);
    end
    send_item(vau_pkg::OP_NORM, 0, 0, 0, one, one, one, one);   // zero vector
    send_item(vau_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0);          // tiny length
    send_item(vau_pkg::OP_NORM, 0, -1, 0, 0, 0, 0, 0);
    send_item(vau_pkg::OP_LEN, 3 * one, 4 * one, 0, 0, 0, 0, 0);
    send_item(vau_pkg::OP_SCALE, one, -one, 32'sh0000_8000, 0, 0, 0, -one);
    send_item(vau_pkg::OP_SCALE, -1, 1, 0, 0, 0, 0, 1);          // floor rounding
    send_item(vau_pkg::OP_CROSS, one, 0, 0, 0, one, 0, 0);
    send_item(vau_pkg::OP_DOT, one, 2 * one, 3 * one, -one, one, one, 0);
    send_item(vau_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int count);
    repeat (count) begin
      send_item(3'($urandom_range(vau_pkg::OP_NORM)), pick_word(), pick_word(), pick_word(),
                pick_word(), pick_word(), pick_word(), pick_word());
    end
  endtask

  always @(posedge clk) begin
    out_ready <= (rst || $urandom_range(99) >= recv_idle_pct);
  end

  always @(negedge clk) begin
    vec_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result x=%h s=%h", $time, res_x, res_scalar);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_x !== want.x) begin
          $display("%0t: res_x expected %h actual %h", $time, want.x, res_x);
          errors++;
        end
        if (res_y !== want.y) begin
          $display("%0t: res_y expected %h actual %h", $time, want.y, res_y);
          errors++;
        end
        if (res_z !== want.z) begin
          $display("%0t: res_z expected %h actual %h", $time, want.z, res_z);
          errors++;
        end
        if (res_scalar !== want.s) begin
          $display("%0t: res_scalar expected %h actual %h", $time, want.s, res_scalar);
          errors++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, saturated);
          errors++;
        end
      end
    end
  end

  // stall watchdog
  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    send_idle_pct = 32;
    recv_idle_pct = 87;
    rst = 1'b1;
    in_valid = 1'b0;
    op = '0;
    a_x = '0; a_y = '0; a_z = '0;
    b_x = '0; b_y = '0; b_z = '0;
    scale_factor = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(120);
    send_idle_pct = 87;
    recv_idle_pct = 32;
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(140);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
